// ===== rtl/cst_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell shape tensor package
// Widths, sequencer states, the shared unit's control struct and small
// arithmetic helpers used by the shape tensor block.
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    localparam int COORD_W = 32;              // Q16.16 vertex coordinate
    localparam int DIFF_W  = COORD_W + 1;     // edge component, signed
    localparam int MAG_W   = COORD_W;         // edge component magnitude
    localparam int PROD_W  = 2 * MAG_W;       // squared component
    localparam int RAD_W   = PROD_W + 2;      // sum of squares, shift register
    localparam int DIVR_W  = 34;              // edge length or perimeter
    localparam int REM_W   = 36;              // partial remainder
    localparam int QUOT_W  = 64;              // quotient or root
    localparam int ACC_W   = 48;              // signed accumulators
    localparam int EQ_W    = 36;              // signed per-edge quotient
    localparam int RAT_W   = 34;              // Q4.30 ratio magnitude
    localparam int FIN_W   = 36;              // signed ratio before clamping
    localparam int THR_W   = 16;
    localparam int PER_W   = 32;
    localparam int RES_W   = 32;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] SQRT_STEPS  = 7'd33;
    localparam logic [CNT_W-1:0] EDIV_STEPS  = 7'd64;
    localparam logic [CNT_W-1:0] RATIO_STEPS = 7'd33;

    localparam logic [RAT_W-1:0] RATIO_SAT = {1'b1, {(RAT_W-1){1'b0}}};
    localparam logic signed [FIN_W-1:0] HALF_Q30 = 36'sh0_2000_0000;
    localparam logic signed [FIN_W-1:0] RES_MAX  = 36'sh0_7FFF_FFFF;
    localparam logic signed [FIN_W-1:0] RES_MIN  = -36'sh0_8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_MXX,
        S_MYY,
        S_MXY,
        S_SQW,
        S_DXXW,
        S_DXYW,
        S_NEXT,
        S_RAT,
        S_RATW,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic             sqrt_mode;
        logic [CNT_W-1:0] steps;
    } t_iter_ctl;

    // Saturating add of a per-edge quotient to an accumulator.
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] s,
        input logic signed [EQ_W-1:0]  q
    );
        logic signed [ACC_W:0] t;
        t = {s[ACC_W-1], s} + {{(ACC_W+1-EQ_W){q[EQ_W-1]}}, q};
        if (t[ACC_W] != t[ACC_W-1]) begin
            sat_add = t[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = t[ACC_W-1:0];
        end
    endfunction

    // Applies the sign, removes one half for the diagonal term and clamps.
    function automatic logic [RES_W-1:0] finish(
        input logic             neg,
        input logic [RAT_W-1:0] r,
        input logic             half
    );
        logic signed [FIN_W-1:0] v;
        v = $signed({2'b00, r});
        if (neg) begin
            v = -v;
        end
        if (half) begin
            v = v - HALF_Q30;
        end
        if (v > RES_MAX) begin
            finish = RES_MAX[RES_W-1:0];
        end else if (v < RES_MIN) begin
            finish = RES_MIN[RES_W-1:0];
        end else begin
            finish = v[RES_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cst_if.sv =====
// ----------------------------------------------------------------------------
// Cell shape tensor channels
// Valid/ready channels for vertices, results and the threshold register.
// ----------------------------------------------------------------------------
`default_nettype none

interface cst_vtx_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  vertex_x;
    logic signed [31:0]  vertex_y;
    logic [31:0]         cell_perimeter;
    logic                last_vertex;

    modport source (output valid, vertex_x, vertex_y, cell_perimeter, last_vertex,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, cell_perimeter, last_vertex,
                    output ready);
endinterface

interface cst_res_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  q_xx;
    logic signed [31:0]  q_xy;

    modport source (output valid, q_xx, q_xy, input ready);
    modport sink   (input valid, q_xx, q_xy, output ready);
endinterface

interface cst_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] length_threshold;

    modport source (output valid, length_threshold, input ready);
    modport sink   (input valid, length_threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/cst_iter_unit.sv =====
// ----------------------------------------------------------------------------
// Shared shift-subtract unit
// Restoring division (one quotient bit a cycle) or integer square root
// (one root bit a cycle) through a single compare-and-subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module cst_iter_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  cst_pkg::t_iter_ctl           i_ctl,
    input  wire [cst_pkg::RAD_W-1:0]     i_num,
    input  wire [cst_pkg::REM_W-1:0]     i_rem,
    input  wire [cst_pkg::DIVR_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [cst_pkg::QUOT_W-1:0]   o_quot
);
    import cst_pkg::*;

    logic [RAD_W-1:0]  r_num;
    logic [REM_W-1:0]  r_rem;
    logic [QUOT_W-1:0] r_q;
    logic [DIVR_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_mode;
    logic              r_done;

    logic [REM_W-1:0]  shifted;
    logic [REM_W-1:0]  operand;
    logic [REM_W:0]    diff;
    logic              ge;

    always_comb begin
        if (r_mode) begin
            shifted = {r_rem[REM_W-3:0], r_num[RAD_W-1:RAD_W-2]};
            operand = {r_q[REM_W-3:0], 2'b01};
        end else begin
            shifted = {r_rem[REM_W-2:0], r_num[RAD_W-1]};
            operand = {{(REM_W-DIVR_W){1'b0}}, r_div};
        end
        diff = {1'b0, shifted} - {1'b0, operand};
        ge   = ~diff[REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num  <= i_num;
            r_rem  <= i_rem;
            r_div  <= i_divisor;
            r_mode <= i_ctl.sqrt_mode;
            r_q    <= '0;
        end else if (r_busy) begin
            r_num <= r_mode ? {r_num[RAD_W-3:0], 2'b00} : {r_num[RAD_W-2:0], 1'b0};
            r_rem <= ge ? diff[REM_W-1:0] : shifted;
            r_q   <= {r_q[QUOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== rtl/cell_shape_q_tensor.sv =====
// ----------------------------------------------------------------------------
// Cell shape tensor
// Traceless shape tensor of a polygonal cell from its ordered vertices.
// ----------------------------------------------------------------------------
// Vertices arrive on i_vtx, one request per vertex, in Q16.16. The request
// with last_vertex set closes the cell and carries its perimeter; one result
// (q_xx, q_xy in Q2.30) then leaves on o_res. Other vertices give no result.
// i_cfg writes the length threshold at any time the block is idle; it is
// always ready. Each edge takes a square root and, if its length exceeds
// the threshold, two divisions, all on the one shift-subtract unit. A last
// vertex adds its closing edge and, if the perimeter exceeds the threshold,
// up to two ratio divisions. i_vtx is ready only while the sequencer waits
// for a vertex. The result sits in an output register; the sequencer stalls
// before writing a new result until the old one has been taken.
// Reset sets the threshold to one and drops any cell in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module cell_shape_q_tensor (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cst_vtx_if.sink    i_vtx,
    cst_cfg_if.sink    i_cfg,
    cst_res_if.source  o_res
);
    import cst_pkg::*;

    t_state r_state, n_state;

    logic [THR_W-1:0]          r_thr;
    logic signed [COORD_W-1:0] r_first_x, n_first_x, r_first_y, n_first_y;
    logic signed [COORD_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic signed [COORD_W-1:0] r_ax, n_ax, r_ay, n_ay, r_bx, n_bx, r_by, n_by;
    logic                      r_have, n_have;
    logic signed [ACC_W-1:0]   r_sum_xx, n_sum_xx, r_sum_xy, n_sum_xy;
    logic [PER_W-1:0]          r_per, n_per;
    logic                      r_last, n_last, r_closing, n_closing;
    logic [MAG_W-1:0]          r_ux, n_ux, r_uy, n_uy;
    logic                      r_neg, n_neg, r_rneg, n_rneg;
    logic [PROD_W-1:0]         r_sx, n_sx, r_sy, n_sy, r_pxy, n_pxy;
    logic [DIVR_W-1:0]         r_len, n_len;
    logic                      r_comp, n_comp;
    logic [RAT_W-1:0]          r_ratio, n_ratio;
    logic [RES_W-1:0]          r_res_xx, n_res_xx, r_res_xy, n_res_xy;
    logic                      r_out_valid, n_out_valid;
    logic [RES_W-1:0]          r_q_xx, n_q_xx, r_q_xy, n_q_xy;

    t_iter_ctl          u_ctl;
    logic [RAD_W-1:0]   u_num;
    logic [REM_W-1:0]   u_rem;
    logic [DIVR_W-1:0]  u_div;
    logic               u_done;
    logic [QUOT_W-1:0]  u_quot;

    logic [MAG_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       prod;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [PROD_W:0]         rad;
    logic signed [ACC_W-1:0] sel_sum;
    logic [ACC_W-1:0]        mag;
    logic signed [EQ_W-1:0]  eq;

    cst_iter_unit u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (u_ctl),
        .i_num     (u_num),
        .i_rem     (u_rem),
        .i_divisor (u_div),
        .o_done    (u_done),
        .o_quot    (u_quot)
    );

    // One multiplier serves all three products of an edge.
    assign mul_a = (r_state == S_MYY) ? r_uy : r_ux;
    assign mul_b = (r_state == S_MXX) ? r_ux : r_uy;
    assign prod  = mul_a * mul_b;

    assign i_cfg.ready  = 1'b1;
    assign i_vtx.ready  = (r_state == S_IDLE);
    assign o_res.valid  = r_out_valid;
    assign o_res.q_xx   = r_q_xx;
    assign o_res.q_xy   = r_q_xy;

    always_comb begin
        n_state   = r_state;
        n_first_x = r_first_x;  n_first_y = r_first_y;
        n_prev_x  = r_prev_x;   n_prev_y  = r_prev_y;
        n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by;
        n_have    = r_have;
        n_sum_xx  = r_sum_xx;   n_sum_xy  = r_sum_xy;
        n_per     = r_per;      n_last    = r_last;
        n_closing = r_closing;
        n_ux = r_ux; n_uy = r_uy; n_neg = r_neg; n_rneg = r_rneg;
        n_sx = r_sx; n_sy = r_sy; n_pxy = r_pxy;
        n_len     = r_len;      n_comp    = r_comp;
        n_ratio   = r_ratio;
        n_res_xx  = r_res_xx;   n_res_xy  = r_res_xy;
        n_out_valid = r_out_valid & ~o_res.ready;
        n_q_xx    = r_q_xx;     n_q_xy    = r_q_xy;
        u_ctl = '0;
        u_num = '0;
        u_rem = '0;
        u_div = '0;

        dx  = $signed({r_bx[COORD_W-1], r_bx}) - $signed({r_ax[COORD_W-1], r_ax});
        dy  = $signed({r_by[COORD_W-1], r_by}) - $signed({r_ay[COORD_W-1], r_ay});
        rad = {1'b0, r_sx} + {1'b0, r_sy};
        sel_sum = r_comp ? r_sum_xy : r_sum_xx;
        mag = sel_sum[ACC_W-1] ? ACC_W'(-sel_sum) : ACC_W'(sel_sum);
        eq  = $signed({1'b0, u_quot[EQ_W-2:0]});

        unique case (r_state)
            S_IDLE: begin
                if (i_vtx.valid) begin
                    n_per     = i_vtx.cell_perimeter;
                    n_last    = i_vtx.last_vertex;
                    n_prev_x  = i_vtx.vertex_x;
                    n_prev_y  = i_vtx.vertex_y;
                    n_bx      = i_vtx.vertex_x;
                    n_by      = i_vtx.vertex_y;
                    n_closing = 1'b0;
                    if (r_have) begin
                        n_ax    = r_prev_x;
                        n_ay    = r_prev_y;
                        n_state = S_DIFF;
                    end else begin
                        n_first_x = i_vtx.vertex_x;
                        n_first_y = i_vtx.vertex_y;
                        n_sum_xx  = '0;
                        n_sum_xy  = '0;
                        n_have    = 1'b1;
                        // A cell of one vertex still runs its zero-length closing edge.
                        if (i_vtx.last_vertex) begin
                            n_ax      = i_vtx.vertex_x;
                            n_ay      = i_vtx.vertex_y;
                            n_closing = 1'b1;
                            n_state   = S_DIFF;
                        end
                    end
                end
            end
            S_DIFF: begin
                n_ux    = dx[DIFF_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
                n_uy    = dy[DIFF_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
                n_neg   = dx[DIFF_W-1] ^ dy[DIFF_W-1];
                n_state = S_MXX;
            end
            S_MXX: begin
                n_sx    = prod;
                n_state = S_MYY;
            end
            S_MYY: begin
                n_sy    = prod;
                n_state = S_MXY;
            end
            S_MXY: begin
                n_pxy           = prod;
                u_ctl.start     = 1'b1;
                u_ctl.sqrt_mode = 1'b1;
                u_ctl.steps     = SQRT_STEPS;
                u_num           = {1'b0, rad};
                n_state         = S_SQW;
            end
            S_SQW: begin
                if (u_done) begin
                    if (u_quot[DIVR_W-1:0] <= {{(DIVR_W-THR_W){1'b0}}, r_thr}) begin
                        n_state = S_NEXT;
                    end else begin
                        n_len       = u_quot[DIVR_W-1:0];
                        u_ctl.start = 1'b1;
                        u_ctl.steps = EDIV_STEPS;
                        u_num       = {r_sx, 2'b00};
                        u_div       = u_quot[DIVR_W-1:0];
                        n_state     = S_DXXW;
                    end
                end
            end
            S_DXXW: begin
                if (u_done) begin
                    n_sum_xx    = sat_add(r_sum_xx, eq);
                    u_ctl.start = 1'b1;
                    u_ctl.steps = EDIV_STEPS;
                    u_num       = {r_pxy, 2'b00};
                    u_div       = r_len;
                    n_state     = S_DXYW;
                end
            end
            S_DXYW: begin
                if (u_done) begin
                    n_sum_xy = sat_add(r_sum_xy, r_neg ? -eq : eq);
                    n_state  = S_NEXT;
                end
            end
            S_NEXT: begin
                if (!r_closing) begin
                    if (r_last) begin
                        n_ax      = r_bx;
                        n_ay      = r_by;
                        n_bx      = r_first_x;
                        n_by      = r_first_y;
                        n_closing = 1'b1;
                        n_state   = S_DIFF;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (r_per <= {{(PER_W-THR_W){1'b0}}, r_thr}) begin
                    n_res_xx = '0;
                    n_res_xy = '0;
                    n_state  = S_OUT;
                end else begin
                    n_comp  = 1'b0;
                    n_state = S_RAT;
                end
            end
            S_RAT: begin
                n_rneg = sel_sum[ACC_W-1];
                // Integer part of eight or more saturates without dividing.
                if (mag >= {{(ACC_W-PER_W-3){1'b0}}, r_per, 3'b000}) begin
                    n_ratio = RATIO_SAT;
                    n_state = S_FIN;
                end else begin
                    u_ctl.start = 1'b1;
                    u_ctl.steps = RATIO_STEPS;
                    u_rem       = mag[REM_W+2:3];
                    u_num       = {mag[2:0], {(RAD_W-3){1'b0}}};
                    u_div       = {{(DIVR_W-PER_W){1'b0}}, r_per};
                    n_state     = S_RATW;
                end
            end
            S_RATW: begin
                if (u_done) begin
                    n_ratio = {1'b0, u_quot[RAT_W-2:0]};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_comp) begin
                    n_res_xx = finish(r_rneg, r_ratio, 1'b1);
                    n_comp   = 1'b1;
                    n_state  = S_RAT;
                end else begin
                    n_res_xy = finish(r_rneg, r_ratio, 1'b0);
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_q_xx      = r_res_xx;
                    n_q_xy      = r_res_xy;
                    n_have      = 1'b0;
                    n_sum_xx    = '0;
                    n_sum_xy    = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= 16'd1;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_thr <= i_cfg.length_threshold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x <= n_first_x;  r_first_y <= n_first_y;
        r_prev_x  <= n_prev_x;   r_prev_y  <= n_prev_y;
        r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
        r_sum_xx  <= n_sum_xx;   r_sum_xy  <= n_sum_xy;
        r_per     <= n_per;      r_last    <= n_last;
        r_closing <= n_closing;
        r_ux <= n_ux; r_uy <= n_uy; r_neg <= n_neg; r_rneg <= n_rneg;
        r_sx <= n_sx; r_sy <= n_sy; r_pxy <= n_pxy;
        r_len     <= n_len;      r_comp    <= n_comp;
        r_ratio   <= n_ratio;
        r_res_xx  <= n_res_xx;   r_res_xy  <= n_res_xy;
        r_q_xx    <= n_q_xx;     r_q_xy    <= n_q_xy;
    end

endmodule

`default_nettype wire

// ===== dv/tb_cell_shape_q_tensor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell shape tensor testbench
// Feeds polygon cells vertex by vertex under several length thresholds,
// predicts the traceless shape tensor of each closed cell and compares every
// result request with the oldest prediction, with random gaps on both sides.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [31:0] q_xx;
    logic signed [31:0] q_xy;
} t_shape;

class shape_scoreboard;
    logic [15:0]    threshold;
    longint         first_x, first_y, prev_x, prev_y;
    bit             in_cell;
    longint         acc_xx, acc_xy;
    t_shape         pending[$];
    int             errors;

    function new();
        threshold = 16'd1;
        in_cell   = 0;
        acc_xx    = 0;
        acc_xy    = 0;
        errors    = 0;
    endfunction

    function logic [63:0] root_floor(logic [67:0] s);
        logic [67:0] r;
        logic [67:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (t * t <= s) begin
                r = t;
            end
        end
        return r[63:0];
    endfunction

    function longint clamp_acc(longint v);
        longint hi;
        hi = (64'sd1 <<< 47) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function void edge_add(longint x0, longint y0, longint x1, longint y1);
        longint        dx, dy;
        logic [63:0]   ux, uy, sx, sy, len;
        logic [67:0]   s;
        dx = x1 - x0;
        dy = y1 - y0;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        sx = ux * ux;
        sy = uy * uy;
        s  = {4'd0, sx} + {4'd0, sy};
        len = root_floor(s);
        if (len <= {48'd0, threshold}) return;
        acc_xx = clamp_acc(acc_xx + longint'(sx / len));
        if ((dx < 0) != (dy < 0)) begin
            acc_xy = clamp_acc(acc_xy - longint'((ux * uy) / len));
        end else begin
            acc_xy = clamp_acc(acc_xy + longint'((ux * uy) / len));
        end
    endfunction

    // Sum over perimeter in Q4.30, truncated toward zero, large ratios pinned.
    function longint ratio_q30(longint s, logic [31:0] p);
        logic [63:0] mag;
        logic [93:0] r;
        mag = (s < 0) ? -s : s;
        if (mag / p >= 8) return (s < 0) ? -(64'sd1 <<< 40) : (64'sd1 <<< 40);
        r = {mag, 30'd0} / {62'd0, p};
        return (s < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function void note_vertex(logic signed [31:0] x, logic signed [31:0] y,
                              logic [31:0] perim, logic last);
        t_shape e;
        if (!in_cell) begin
            first_x = x;
            first_y = y;
            acc_xx  = 0;
            acc_xy  = 0;
            in_cell = 1;
        end else begin
            edge_add(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (!last) return;
        edge_add(x, y, first_x, first_y);
        if (perim <= {16'd0, threshold}) begin
            e.q_xx = '0;
            e.q_xy = '0;
        end else begin
            e.q_xx = clamp32(ratio_q30(acc_xx, perim) - (64'sd1 <<< 29));
            e.q_xy = clamp32(ratio_q30(acc_xy, perim));
        end
        pending.push_back(e);
        in_cell = 0;
        acc_xx  = 0;
        acc_xy  = 0;
    endfunction

    function void check_result(logic signed [31:0] q_xx, logic signed [31:0] q_xy);
        t_shape e;
        if (pending.size() == 0) begin
            $error("unexpected result q_xx=%0d q_xy=%0d", q_xx, q_xy);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (q_xx !== e.q_xx) begin
            $error("q_xx expected %0d actual %0d", e.q_xx, q_xx);
            errors++;
        end
        if (q_xy !== e.q_xy) begin
            $error("q_xy expected %0d actual %0d", e.q_xy, q_xy);
            errors++;
        end
    endfunction
endclass

module tb_cell_shape_q_tensor;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    bit   no_gaps = 0;
    int   res_wait = 0;

    cst_vtx_if vtx();
    cst_res_if res();
    cst_cfg_if cfg();

    shape_scoreboard sb = new();

    cell_shape_q_tensor dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx.sink),
        .i_cfg  (cfg.sink),
        .o_res  (res.source)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cell_shape_q_tensor verification failed");
            $finish;
        end
    end

    // Result side: random stall drawn per request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            res_wait  <= 0;
        end else if (res.valid && res.ready) begin
            sb.check_result(res.q_xx, res.q_xy);
            if (no_gaps) begin
                res.ready <= 1'b1;
            end else begin
                res_wait  <= $urandom_range(0, 8);
                res.ready <= 1'b0;
            end
        end else if (res_wait > 0) begin
            res_wait  <= res_wait - 1;
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic [31:0] perim, logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            vtx.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        vtx.valid          <= 1'b1;
        vtx.vertex_x       <= x;
        vtx.vertex_y       <= y;
        vtx.cell_perimeter <= perim;
        vtx.last_vertex    <= last;
        do @(posedge i_clk); while (!vtx.ready);
        sb.note_vertex(x, y, perim, last);
    endtask

    // Waits out every pending result plus the longest cell so the block is idle.
    task automatic drain();
        @(posedge i_clk);
        vtx.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [15:0] thr);
        cfg.valid            <= 1'b1;
        cfg.length_threshold <= thr;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.threshold = thr;
    endtask

    // One random cell; returns the number of vertices sent.
    task automatic random_cell(output int n);
        logic signed [31:0] cx, cy, x, y;
        longint             span, pl;
        logic [31:0]        perim;
        int                 kind;
        kind = $urandom_range(0, 99);
        n    = $urandom_range(2, 8);
        case ($urandom_range(0, 3))
            0: span = $urandom_range(1, 1 << 17);
            1: span = $urandom_range(1, 1 << 22);
            2: span = $urandom_range(1, 1 << 27);
            default: span = 64'd1 << 31;
        endcase
        cx = $urandom;
        cy = $urandom;
        if (kind < 5) n = 1;
        pl = longint'(n) * span * $urandom_range(1, 6) / 2;
        if (pl > 64'hFFFF_FFFF) pl = 64'hFFFF_FFFF;
        perim = pl[31:0];
        if (kind >= 95) perim = $urandom;
        else if (kind >= 90) perim = $urandom_range(0, 65535);
        for (int i = 0; i < n; i++) begin
            x = cx + 32'(longint'($urandom) % span);
            y = cy + 32'(longint'($urandom) % span);
            if (kind >= 5 && kind < 15 && i > 0 && $urandom_range(0, 1)) begin
                x = cx;
                y = cy;
            end
            cx = x;
            cy = y;
            send_vertex(x, y, perim, i == n - 1);
        end
    endtask

    initial begin
        logic [15:0] thr_list[5];
        int          sent, n;
        i_rst_n              <= 1'b0;
        vtx.valid            <= 1'b0;
        vtx.vertex_x         <= '0;
        vtx.vertex_y         <= '0;
        vtx.cell_perimeter   <= '0;
        vtx.last_vertex      <= 1'b0;
        cfg.valid            <= 1'b0;
        cfg.length_threshold <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cells at the reset threshold.
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b1);
        send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'h0010_0000, 1'b1);
        send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'd0, 1'b1);
        send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'd1, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'd2, 1'b0);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'd2, 1'b0);
        send_vertex(32'sh0100_0000, 32'sh0000_0000, 32'd2, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'h0004_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0000_0000, 32'h0004_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'h0004_0000, 1'b0);
        send_vertex(32'sh0000_0000, 32'sh0001_0000, 32'h0004_0000, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'h0003_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0001_0000, 32'h0003_0000, 1'b1);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'h0003_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'shFFFF_0000, 32'h0003_0000, 1'b1);
        send_vertex(32'sh0000_0001, 32'sh0000_0000, 32'h0000_1000, 1'b0);
        send_vertex(32'sh0000_0002, 32'sh0000_0000, 32'h0000_1000, 1'b1);
        drain();

        thr_list[0] = 16'd0;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = 16'($urandom_range(2, 65534));
        thr_list[3] = 16'($urandom_range(0, 255));
        thr_list[4] = 16'd1;
        foreach (thr_list[p]) begin
            write_threshold(thr_list[p]);
            sent = 0;
            while (sent < 250) begin
                no_gaps = ($urandom_range(0, 9) == 0);
                random_cell(n);
                sent += n;
            end
            no_gaps = 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("cell_shape_q_tensor verification clean");
        end else begin
            $display("cell_shape_q_tensor verification failed");
        end
        $finish;
    end
endmodule
